// ===== rtl/core/lbca_pkg.sv =====
`timescale 1ns / 1ps

package lbca_pkg;

  // Fixed field widths of the item and result ports
  localparam int FUNC_W   = 2;
  localparam int IDX_W    = 4;
  localparam int SIZE_W   = 17;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 3;
  localparam int SLOT_O_W = 4;
  localparam int BLK_O_W  = 7;

  // Link table entry: next block, or one of two marks
  localparam int LINK_W = 9;
  localparam logic [LINK_W-1:0] LINK_FREE = 9'd511;
  localparam logic [LINK_W-1:0] LINK_END  = 9'd510;

  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC  = 2'd0,
    FN_RESIZE = 2'd1,
    FN_LOCATE = 2'd2,
    FN_DELETE = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_NO_SLOT  = 3'd1,
    ST_NO_BLOCK = 3'd2,
    ST_UNUSED   = 3'd3,
    ST_BEYOND   = 3'd4
  } status_t;

  // Datapath micro-operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_SLOT_RD,
    OP_WALK_INIT,
    OP_KEEP_INIT,
    OP_LINK_RD,
    OP_LINK_NEXT,
    OP_FREE_NEXT,
    OP_TRUNC,
    OP_CNT_CLR,
    OP_CNT_INC,
    OP_SCAN_RD,
    OP_SCAN_CNT,
    OP_SLOT_PICK,
    OP_ALLOC_WR,
    OP_EXT_LINK,
    OP_EXT_END,
    OP_RES_NOSLOT,
    OP_RES_STATUS,
    OP_RES_OLD,
    OP_LOC_OK,
    OP_RESIZE_OK,
    OP_DELETE_WR,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t     op;
    status_t code;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  idx_ok;
    logic  slot_free;
    logic  cnt_lt_nf;
    logic  cnt_lt_nb;
    logic  rd_free;
    logic  b_ok;
    logic  len_lt_nb;
    logic  len_lt_pos;
    logic  size_gt_acc;
    logic  size_gt_acc2;
    logic  shrink;
  } stat_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_INIT,
    S_ALLOC_SLOT,
    S_ALLOC_RD,
    S_ALLOC_W,
    S_WALK,
    S_WALK_N,
    S_DECIDE,
    S_CNT_RD,
    S_CNT_W,
    S_CNT_DEC,
    S_EXT,
    S_EXT_W,
    S_EXT_E,
    S_KEEP,
    S_KEEP_N,
    S_TRUNC,
    S_FREE,
    S_FREE_N,
    S_LOC,
    S_LOC_N,
    S_DONE
  } state_t;

endpackage

// ===== rtl/core/lbca_dp.sv =====
`timescale 1ns / 1ps

module lbca_dp import lbca_pkg::*; #(
  parameter int NUM_FILES   = 16,
  parameter int BLOCK_COUNT = 128,
  parameter int BLOCK_BYTES = 512
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output stat_t               stat,
  input  logic [FUNC_W-1:0]   func,
  input  logic [IDX_W-1:0]    file_index,
  input  logic [SIZE_W-1:0]   size_bytes,
  input  logic [POS_W-1:0]    chain_position,
  output logic [STATUS_W-1:0] status,
  output logic [SLOT_O_W-1:0] slot_out,
  output logic [BLK_O_W-1:0]  block_out,
  output logic [SIZE_W-1:0]   size_out
);

  localparam int FIW  = $clog2(NUM_FILES);
  localparam int BIW  = $clog2(BLOCK_COUNT);
  localparam int LW   = $clog2(BLOCK_COUNT + 1);
  localparam int MAXN = (NUM_FILES > BLOCK_COUNT) ? NUM_FILES : BLOCK_COUNT;
  localparam int SCW  = $clog2(MAXN + 1);
  localparam int AW   = $clog2(2 * BLOCK_COUNT * BLOCK_BYTES + (1 << SIZE_W)) + 1;
  localparam logic [AW-1:0] BB_A = AW'(BLOCK_BYTES);

  // Latched item
  func_t             func_q;
  logic [IDX_W-1:0]  idx_q;
  logic [SIZE_W-1:0] size_q;
  logic [POS_W-1:0]  pos_q;

  // Walk and scan registers
  logic [BIW-1:0] b_q;
  logic           b_ok_q;
  logic [BIW-1:0] last_q;
  logic [SCW-1:0] cnt_q;
  logic [LW-1:0]  len_q;
  logic [AW-1:0]  acc_q;
  logic [AW-1:0]  acc2_q;
  logic [FIW-1:0] sel_q;

  // Pending result
  status_t             res_status;
  logic [SLOT_O_W-1:0] res_slot;
  logic [BLK_O_W-1:0]  res_blk;
  logic [SIZE_W-1:0]   res_sz;

  // Link table with per-entry written flags
  logic [LINK_W-1:0] link_mem [BLOCK_COUNT];
  logic              link_vld [BLOCK_COUNT];
  logic [LINK_W-1:0] rd_mem_q;
  logic              rd_vld_q;
  logic [LINK_W-1:0] rd_link;
  logic              rd_next_ok;

  // Slot tables
  logic [BIW-1:0]    first_mem [NUM_FILES];
  logic [SIZE_W-1:0] size_mem  [NUM_FILES];
  logic              used      [NUM_FILES];
  logic [BIW-1:0]    first_rd;
  logic [SIZE_W-1:0] size_rd;

  logic              lr_en;
  logic [BIW-1:0]    lr_addr;
  logic              lw_en;
  logic [BIW-1:0]    lw_addr;
  logic [LINK_W-1:0] lw_data;
  logic [AW-1:0]     size_ext;

  assign rd_link    = rd_vld_q ? rd_mem_q : LINK_FREE;
  assign rd_next_ok = rd_link < LINK_W'(BLOCK_COUNT);
  assign size_ext   = AW'(size_q);

  // Link table port selection
  always_comb begin
    lr_en   = 1'b0;
    lr_addr = b_q;
    lw_en   = 1'b0;
    lw_addr = b_q;
    lw_data = LINK_END;
    case (cmd.op)
      OP_LINK_RD: begin
        lr_en = 1'b1;
      end
      OP_SCAN_RD: begin
        lr_en   = 1'b1;
        lr_addr = BIW'(cnt_q);
      end
      OP_FREE_NEXT: begin
        lw_en   = 1'b1;
        lw_data = LINK_FREE;
      end
      OP_TRUNC: begin
        lw_en = 1'b1;
      end
      OP_ALLOC_WR, OP_EXT_END: begin
        lw_en   = 1'b1;
        lw_addr = BIW'(cnt_q);
      end
      OP_EXT_LINK: begin
        lw_en   = 1'b1;
        lw_addr = last_q;
        lw_data = LINK_W'(cnt_q);
      end
      default: begin
      end
    endcase
  end

  // Link table storage, registered read
  always_ff @(posedge clk) begin
    if (lw_en) begin
      link_mem[lw_addr] <= lw_data;
    end
    if (lr_en) begin
      rd_mem_q <= link_mem[lr_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BLOCK_COUNT; i++) begin
        link_vld[i] <= 1'b0;
      end
      rd_vld_q <= 1'b0;
    end else begin
      if (lw_en) begin
        link_vld[lw_addr] <= 1'b1;
      end
      if (lr_en) begin
        rd_vld_q <= link_vld[lr_addr];
      end
    end
  end

  // Slot tables: first block and size
  always_ff @(posedge clk) begin
    if (cmd.op == OP_ALLOC_WR) begin
      first_mem[sel_q] <= BIW'(cnt_q);
      size_mem[sel_q]  <= '0;
    end
    if (cmd.op == OP_RESIZE_OK) begin
      size_mem[FIW'(idx_q)] <= size_q;
    end
    if (cmd.op == OP_SLOT_RD) begin
      first_rd <= first_mem[FIW'(idx_q)];
      size_rd  <= size_mem[FIW'(idx_q)];
    end
  end

  // Slot in-use flags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_FILES; i++) begin
        used[i] <= 1'b0;
      end
    end else if (cmd.op == OP_ALLOC_WR) begin
      used[sel_q] <= 1'b1;
    end else if (cmd.op == OP_DELETE_WR) begin
      used[FIW'(idx_q)] <= 1'b0;
    end
  end

  // Working registers and result
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LATCH: begin
        func_q     <= func_t'(func);
        idx_q      <= file_index;
        size_q     <= size_bytes;
        pos_q      <= chain_position;
        res_status <= ST_OK;
        res_slot   <= file_index;
        res_blk    <= '0;
        res_sz     <= '0;
      end
      OP_WALK_INIT: begin
        b_q    <= first_rd;
        b_ok_q <= 1'b1;
        len_q  <= '0;
        acc_q  <= '0;
      end
      OP_KEEP_INIT: begin
        b_q    <= first_rd;
        b_ok_q <= 1'b1;
        acc_q  <= BB_A;
      end
      OP_LINK_RD: begin
        last_q <= b_q;
        len_q  <= len_q + LW'(1);
        acc_q  <= acc_q + BB_A;
      end
      OP_LINK_NEXT, OP_FREE_NEXT: begin
        b_q    <= BIW'(rd_link);
        b_ok_q <= rd_next_ok;
      end
      OP_TRUNC: begin
        b_q    <= BIW'(rd_link);
        b_ok_q <= rd_next_ok;
        len_q  <= '0;
      end
      OP_CNT_CLR: begin
        cnt_q  <= '0;
        acc2_q <= acc_q;
      end
      OP_CNT_INC: begin
        cnt_q <= cnt_q + SCW'(1);
      end
      OP_SCAN_CNT: begin
        cnt_q <= cnt_q + SCW'(1);
        if (rd_link == LINK_FREE) begin
          acc2_q <= acc2_q + BB_A;
        end
      end
      OP_SLOT_PICK: begin
        sel_q    <= FIW'(cnt_q);
        res_slot <= SLOT_O_W'(cnt_q);
        cnt_q    <= '0;
      end
      OP_ALLOC_WR: begin
        res_blk <= BLK_O_W'(cnt_q);
      end
      OP_EXT_LINK: begin
        len_q <= len_q + LW'(1);
        acc_q <= acc_q + BB_A;
      end
      OP_EXT_END: begin
        last_q <= BIW'(cnt_q);
        cnt_q  <= cnt_q + SCW'(1);
      end
      OP_RES_NOSLOT: begin
        res_status <= ST_NO_SLOT;
        res_slot   <= '0;
      end
      OP_RES_STATUS: begin
        res_status <= cmd.code;
      end
      OP_RES_OLD: begin
        res_status <= cmd.code;
        res_sz     <= size_rd;
      end
      OP_LOC_OK: begin
        res_blk <= BLK_O_W'(b_q);
        res_sz  <= size_rd;
      end
      OP_RESIZE_OK: begin
        res_sz <= size_q;
      end
      OP_EMIT: begin
        status    <= res_status;
        slot_out  <= res_slot;
        block_out <= res_blk;
        size_out  <= res_sz;
      end
      default: begin
      end
    endcase
  end

  // Status to the controller
  always_comb begin
    stat.func         = func_q;
    stat.idx_ok       = (32'(idx_q) < NUM_FILES) && used[FIW'(idx_q)];
    stat.slot_free    = !used[FIW'(cnt_q)];
    stat.cnt_lt_nf    = 32'(cnt_q) < NUM_FILES;
    stat.cnt_lt_nb    = 32'(cnt_q) < BLOCK_COUNT;
    stat.rd_free      = rd_link == LINK_FREE;
    stat.b_ok         = b_ok_q;
    stat.len_lt_nb    = 32'(len_q) < BLOCK_COUNT;
    stat.len_lt_pos   = 32'(len_q) < 32'(pos_q);
    stat.size_gt_acc  = size_ext > acc_q;
    stat.size_gt_acc2 = size_ext > acc2_q;
    stat.shrink       = (len_q > LW'(1)) && (size_ext + BB_A <= acc_q);
  end

endmodule

// ===== rtl/core/lbca_ctrl.sv =====
`timescale 1ns / 1ps

module lbca_ctrl import lbca_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  // State register and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.op == OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign in_ready = (state == S_IDLE);

  // Sequencer
  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    cmd.code   = ST_OK;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LATCH;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.func == FN_ALLOC) begin
          cmd.op     = OP_CNT_CLR;
          state_next = S_ALLOC_SLOT;
        end else if (!stat.idx_ok) begin
          cmd.op     = OP_RES_STATUS;
          cmd.code   = ST_UNUSED;
          state_next = S_DONE;
        end else begin
          cmd.op     = OP_SLOT_RD;
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        cmd.op = OP_WALK_INIT;
        case (stat.func)
          FN_RESIZE: state_next = S_WALK;
          FN_LOCATE: state_next = S_LOC;
          default:   state_next = S_FREE;
        endcase
      end
      // Allocate: lowest unused slot, then lowest free block
      S_ALLOC_SLOT: begin
        if (!stat.cnt_lt_nf) begin
          cmd.op     = OP_RES_NOSLOT;
          state_next = S_DONE;
        end else if (stat.slot_free) begin
          cmd.op     = OP_SLOT_PICK;
          state_next = S_ALLOC_RD;
        end else begin
          cmd.op = OP_CNT_INC;
        end
      end
      S_ALLOC_RD: begin
        if (stat.cnt_lt_nb) begin
          cmd.op     = OP_SCAN_RD;
          state_next = S_ALLOC_W;
        end else begin
          cmd.op     = OP_RES_STATUS;
          cmd.code   = ST_NO_BLOCK;
          state_next = S_DONE;
        end
      end
      S_ALLOC_W: begin
        if (stat.rd_free) begin
          cmd.op     = OP_ALLOC_WR;
          state_next = S_DONE;
        end else begin
          cmd.op     = OP_CNT_INC;
          state_next = S_ALLOC_RD;
        end
      end
      // Resize: measure the chain
      S_WALK: begin
        if (stat.b_ok && stat.len_lt_nb) begin
          cmd.op     = OP_LINK_RD;
          state_next = S_WALK_N;
        end else begin
          state_next = S_DECIDE;
        end
      end
      S_WALK_N: begin
        cmd.op     = OP_LINK_NEXT;
        state_next = S_WALK;
      end
      S_DECIDE: begin
        if (stat.size_gt_acc) begin
          cmd.op     = OP_CNT_CLR;
          state_next = S_CNT_RD;
        end else if (stat.shrink) begin
          cmd.op     = OP_KEEP_INIT;
          state_next = S_KEEP;
        end else begin
          cmd.op     = OP_RESIZE_OK;
          state_next = S_DONE;
        end
      end
      // Grow: count free blocks first
      S_CNT_RD: begin
        if (stat.cnt_lt_nb) begin
          cmd.op     = OP_SCAN_RD;
          state_next = S_CNT_W;
        end else begin
          state_next = S_CNT_DEC;
        end
      end
      S_CNT_W: begin
        cmd.op     = OP_SCAN_CNT;
        state_next = S_CNT_RD;
      end
      S_CNT_DEC: begin
        if (stat.size_gt_acc2) begin
          cmd.op     = OP_RES_OLD;
          cmd.code   = ST_NO_BLOCK;
          state_next = S_DONE;
        end else begin
          cmd.op     = OP_CNT_CLR;
          state_next = S_EXT;
        end
      end
      // Grow: append lowest free blocks in one ascending pass
      S_EXT: begin
        if (stat.size_gt_acc && stat.cnt_lt_nb) begin
          cmd.op     = OP_SCAN_RD;
          state_next = S_EXT_W;
        end else begin
          cmd.op     = OP_RESIZE_OK;
          state_next = S_DONE;
        end
      end
      S_EXT_W: begin
        if (stat.rd_free) begin
          cmd.op     = OP_EXT_LINK;
          state_next = S_EXT_E;
        end else begin
          cmd.op     = OP_CNT_INC;
          state_next = S_EXT;
        end
      end
      S_EXT_E: begin
        cmd.op     = OP_EXT_END;
        state_next = S_EXT;
      end
      // Shrink: find the new last block
      S_KEEP: begin
        cmd.op = OP_LINK_RD;
        if (stat.size_gt_acc) begin
          state_next = S_KEEP_N;
        end else begin
          state_next = S_TRUNC;
        end
      end
      S_KEEP_N: begin
        cmd.op     = OP_LINK_NEXT;
        state_next = S_KEEP;
      end
      S_TRUNC: begin
        cmd.op     = OP_TRUNC;
        state_next = S_FREE;
      end
      // Free a chain tail (resize) or a whole chain (delete)
      S_FREE: begin
        if (stat.b_ok && stat.len_lt_nb) begin
          cmd.op     = OP_LINK_RD;
          state_next = S_FREE_N;
        end else if (stat.func == FN_DELETE) begin
          cmd.op     = OP_DELETE_WR;
          state_next = S_DONE;
        end else begin
          cmd.op     = OP_RESIZE_OK;
          state_next = S_DONE;
        end
      end
      S_FREE_N: begin
        cmd.op     = OP_FREE_NEXT;
        state_next = S_FREE;
      end
      // Locate
      S_LOC: begin
        if (stat.b_ok && stat.len_lt_pos) begin
          cmd.op     = OP_LINK_RD;
          state_next = S_LOC_N;
        end else if (stat.b_ok) begin
          cmd.op     = OP_LOC_OK;
          state_next = S_DONE;
        end else begin
          cmd.op     = OP_RES_OLD;
          cmd.code   = ST_BEYOND;
          state_next = S_DONE;
        end
      end
      S_LOC_N: begin
        cmd.op     = OP_LINK_NEXT;
        state_next = S_LOC;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/linked_block_chain_allocator.sv =====
`timescale 1ns / 1ps

// Linked block chain allocator: a file slot table and a block link table,
// serving allocate, resize, locate and delete, one transaction at a time.
// Each chain or scan step reads the single-port link table, which has a
// registered read, and then acts on the entry read. Allocate scans for
// the lowest unused slot and then the lowest free block; locate walks the
// chain to the chain position; delete walks and frees the whole chain.
// A resize walks its chain; when it grows it also counts all free blocks
// by scanning the whole link table and makes one ascending pass to the
// last block appended; when it shrinks it walks to the new last block and
// frees the tail. The result sits in an output register, so the next
// transaction is accepted while a result still waits to be taken. Reset
// marks all slots unused and all blocks free at once; no clearing pass.

module linked_block_chain_allocator import lbca_pkg::*; #(
  parameter int NUM_FILES   = 16,
  parameter int BLOCK_COUNT = 128,
  parameter int BLOCK_BYTES = 512
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [FUNC_W-1:0]   func,
  input  logic [IDX_W-1:0]    file_index,
  input  logic [SIZE_W-1:0]   size_bytes,
  input  logic [POS_W-1:0]    chain_position,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [SLOT_O_W-1:0] slot_out,
  output logic [BLK_O_W-1:0]  block_out,
  output logic [SIZE_W-1:0]   size_out
);

  cmd_t  cmd;
  stat_t stat;

  lbca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lbca_dp #(
    .NUM_FILES   (NUM_FILES),
    .BLOCK_COUNT (BLOCK_COUNT),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .func           (func),
    .file_index     (file_index),
    .size_bytes     (size_bytes),
    .chain_position (chain_position),
    .status         (status),
    .slot_out       (slot_out),
    .block_out      (block_out),
    .size_out       (size_out)
  );

endmodule

// ===== rtl/core/lbca_checker.sv =====
`timescale 1ns / 1ps

module lbca_checker import lbca_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] status,
  input logic [SLOT_O_W-1:0] slot_out,
  input logic [BLK_O_W-1:0]  block_out,
  input logic [SIZE_W-1:0]   size_out
);

  // An accepted transaction keeps the block busy for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted back to back");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot_out)
      && $stable(block_out) && $stable(size_out))
    else $error("result changed while stalled");

  // Only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= ST_BEYOND))
    else $error("undefined status code");

  // No free slot carries an all-zero result
  a_no_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_NO_SLOT |-> slot_out == '0 && block_out == '0
      && size_out == '0)
    else $error("no-slot result not cleared");

  // Unused slot reports no block and no size
  a_unused: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_UNUSED |-> block_out == '0 && size_out == '0)
    else $error("unused-slot result not cleared");

endmodule

bind linked_block_chain_allocator lbca_checker u_lbca_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .status    (status),
  .slot_out  (slot_out),
  .block_out (block_out),
  .size_out  (size_out)
);
